/* sv/st2d_pkg.sv */
// Shared types and constants for the radius-2 star stencil unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package st2d_pkg;

  // Field widths
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 24;
  localparam int GRID_W     = 12;
  localparam int BORDER_W   = 10;
  localparam int DIR_W      = 2 * COEF_W;
  localparam int POS_W      = 11;

  // Stencil geometry: four buffered rows plus the incoming sample
  localparam int RADIUS     = 2;
  localparam int LANES      = 4;
  localparam int LANE_W     = 2;
  localparam int TAPS       = 9;
  localparam int GROUP_SIZE = 3;
  localparam int GROUPS     = TAPS / GROUP_SIZE;

  // Arithmetic widths: Q4.20 times Q16.16, nine terms summed
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int PSUM_W     = PROD_W + 2;
  localparam int ACC_W      = PROD_W + 4;
  localparam int FRAC_SHIFT = 20;
  localparam int QUO_W      = ACC_W - FRAC_SHIFT;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 32'h8000_0000;

  // Result queue depth, also the limit on results in flight
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = 3;
  localparam int OUT_CNT_W  = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = DIR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS   = 4'd0,
    REG_GRID_ROWS   = 4'd1,
    REG_BORDER      = 4'd2,
    REG_COEF_CENTER = 4'd3,
    REG_COEF_WEST   = 4'd4,
    REG_COEF_EAST   = 4'd5,
    REG_COEF_NORTH  = 4'd6,
    REG_COEF_SOUTH  = 4'd7
  } st2d_cfg_reg_e;

  // Register reset values: -30/12 center, 16/12 near, -1/12 far
  localparam logic [GRID_W-1:0]   GRID_COLS_RST = 12'd2048;
  localparam logic [GRID_W-1:0]   GRID_ROWS_RST = 12'd2048;
  localparam logic [BORDER_W-1:0] BORDER_RST    = 10'd2;
  localparam logic [COEF_W-1:0]   COEF_C_RST    = 24'hD8_0000;
  localparam logic [DIR_W-1:0]    COEF_DIR_RST  = 48'hFEAAAB_155555;

  // Tap order inside the multiply array
  localparam int TAP_C  = 0;
  localparam int TAP_W1 = 1;
  localparam int TAP_W2 = 2;
  localparam int TAP_E1 = 3;
  localparam int TAP_E2 = 4;
  localparam int TAP_N1 = 5;
  localparam int TAP_N2 = 6;
  localparam int TAP_S1 = 7;
  localparam int TAP_S2 = 8;

  // One line store word: the four buffered rows at one column
  typedef logic [LANES-1:0][SAMPLE_W-1:0] st2d_col_t;
  typedef logic [TAPS-1:0][SAMPLE_W-1:0]  st2d_taps_t;
  typedef logic [TAPS-1:0][COEF_W-1:0]    st2d_coefs_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } st2d_tag_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    st2d_tag_t           tag;
  } st2d_res_t;

endpackage

/* sv/st2d_mac.sv */
// Multiply-accumulate pipeline: nine signed products, a registered adder tree,
// rounding, shift and saturation. Depends on st2d_pkg.
`timescale 1ns / 1ps

module st2d_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  st2d_pkg::st2d_taps_t  taps_i,
  input  st2d_pkg::st2d_coefs_t coefs_i,
  input  st2d_pkg::st2d_tag_t   tag_i,
  output logic                valid_o,
  output st2d_pkg::st2d_res_t   res_o
);
  import st2d_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic                     prod_vld_q, psum_vld_q, acc_vld_q, out_vld_q;
  st2d_tag_t                prod_tag_q, psum_tag_q, acc_tag_q;
  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic signed [PSUM_W-1:0] psum_q [GROUPS];
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic [QUO_W-1:0]         quo;
  logic [QUO_W-SAMPLE_W:0]  quo_top;
  logic [SAMPLE_W-1:0]      sat;
  st2d_res_t                res_q;

  // Advance valid bits through the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      psum_vld_q <= 1'b0;
      acc_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      psum_vld_q <= prod_vld_q;
      acc_vld_q  <= psum_vld_q;
      out_vld_q  <= acc_vld_q;
    end
  end

  // Products, one multiplier per tap
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TAPS; i++) begin
      prod_q[i] <= $signed(coefs_i[i]) * $signed(taps_i[i]);
    end
    prod_tag_q <= tag_i;
  end

  // Partial sums of three products each
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < GROUPS; j++) begin
      psum_q[j] <= PSUM_W'(prod_q[GROUP_SIZE*j]) + PSUM_W'(prod_q[GROUP_SIZE*j + 1])
                 + PSUM_W'(prod_q[GROUP_SIZE*j + 2]);
    end
    psum_tag_q <= prod_tag_q;
  end

  // Full sum
  always_ff @(posedge clk_i) begin
    acc_q      <= ACC_W'(psum_q[0]) + ACC_W'(psum_q[1]) + ACC_W'(psum_q[2]);
    acc_tag_q  <= psum_tag_q;
  end

  // Round half up, drop fraction bits, clip to 32 bits
  always_comb begin
    rnd     = acc_q + RND_HALF;
    quo     = rnd[ACC_W-1:FRAC_SHIFT];
    quo_top = quo[QUO_W-1:SAMPLE_W-1];
    if ((&quo_top) || !(|quo_top)) begin
      sat = quo[SAMPLE_W-1:0];
    end else if (quo[QUO_W-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.value <= sat;
    res_q.tag   <= acc_tag_q;
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

endmodule

/* sv/st2d_fifo.sv */
// Result queue between the arithmetic pipeline and the output channel.
// Depends on st2d_pkg for the entry type and depth.
`timescale 1ns / 1ps

module st2d_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  st2d_pkg::st2d_res_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output st2d_pkg::st2d_res_t data_o
);
  import st2d_pkg::*;

  st2d_res_t              slot_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0]   count_q;

  // Store entries; the head holds until it is taken
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + OUT_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - OUT_CNT_W'(1);
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

endmodule

/* sv/stencil_2d_star_radius2_unit.sv */
// Top level of the radius-2 nine-point star stencil unit.
// Depends on st2d_pkg, st2d_mac and st2d_fifo.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o): one Q16.16 sample per transfer in
//   raster order; frame_start_i marks row 0, column 0 of a grid.
//   Output channel (out_valid_o / out_stall_i): one transfer per interior cell,
//   carrying the Q16.16 result, its row and column, and last on the final cell.
//   Config channel (cfg_valid_i / cfg_ready_o): register index and data; always
//   ready; write only while no results are outstanding.
//   Throughput: one sample per cycle while in_stall_o is low, set by one line
//   store write and one read a cycle (lane write at column x, full-column read
//   two columns ahead in the raster, wrapping into the next row).
//   Path: a cell's result is offered once the sample two rows below it has
//   passed the window stage, the four st2d_mac stages and the queue write.
//   Stall: results queue in an eight-entry buffer; input is held off only when
//   the line store is zeroed or eight accepted results are not yet taken, so
//   input keeps flowing while a finished result waits.
//   Reset: registers return to their reset values and the line store is zeroed
//   one column word per cycle over all MAX_COLS columns, with in_stall_o high
//   meanwhile; configuration writes are accepted during that pass.
module stencil_2d_star_radius2_unit #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [st2d_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  frame_start_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [st2d_pkg::SAMPLE_W-1:0]  value_o,
  output logic [st2d_pkg::POS_W-1:0]            row_o,
  output logic [st2d_pkg::POS_W-1:0]            col_o,
  output logic                                  last_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [st2d_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [st2d_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import st2d_pkg::*;

  localparam int ColW    = $clog2(MAX_COLS);
  localparam int RowW    = $clog2(MAX_ROWS);
  localparam int SizeMax = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int CmpW    = $clog2(SizeMax + (1 << GRID_W) + (1 << BORDER_W));

  // Configuration registers
  logic [GRID_W-1:0]   grid_cols_q, grid_rows_q;
  logic [BORDER_W-1:0] border_q;
  logic [COEF_W-1:0]   coef_c_q;
  logic [DIR_W-1:0]    coef_w_q, coef_e_q, coef_n_q, coef_s_q;

  // Position, clearing and credit state
  logic [ColW-1:0]      col_q, clr_addr_q;
  logic [RowW-1:0]      row_q;
  logic                 clr_q;
  logic [OUT_CNT_W-1:0] cnt_q;

  // Line store and column window
  st2d_col_t            line_mem [MAX_COLS];
  st2d_col_t            rd_q, w0_q, w1_q;
  logic [SAMPLE_W-1:0]  c1_q, c2_q;

  // Window stage
  logic                 s1_vld_q;
  logic [SAMPLE_W-1:0]  s1_smp_q;
  logic [LANE_W-1:0]    s1_lane_q;
  st2d_tag_t            s1_tag_q;

  logic [CmpW-1:0]      cols, rows, bord, x0, y0, x, y, cr, x_inc, y_inc, x_rd;
  logic                 interior, is_last, accept, pop;
  logic [LANE_W-1:0]    lane_ctr, ln_n1, ln_c, ln_s1;
  st2d_taps_t           taps;
  st2d_coefs_t          coefs;
  logic                 mac_vld, fifo_vld;
  st2d_res_t            mac_res, fifo_res;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign pop         = fifo_vld && !out_stall_i;
  assign in_stall_o  = clr_q || (cnt_q >= OUT_CNT_W'(OUT_DEPTH));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GRID_COLS_RST;
      grid_rows_q <= GRID_ROWS_RST;
      border_q    <= BORDER_RST;
      coef_c_q    <= COEF_C_RST;
      coef_w_q    <= COEF_DIR_RST;
      coef_e_q    <= COEF_DIR_RST;
      coef_n_q    <= COEF_DIR_RST;
      coef_s_q    <= COEF_DIR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GRID_COLS:   grid_cols_q <= cfg_data_i[GRID_W-1:0];
        REG_GRID_ROWS:   grid_rows_q <= cfg_data_i[GRID_W-1:0];
        REG_BORDER:      border_q    <= cfg_data_i[BORDER_W-1:0];
        REG_COEF_CENTER: coef_c_q    <= cfg_data_i[COEF_W-1:0];
        REG_COEF_WEST:   coef_w_q    <= cfg_data_i[DIR_W-1:0];
        REG_COEF_EAST:   coef_e_q    <= cfg_data_i[DIR_W-1:0];
        REG_COEF_NORTH:  coef_n_q    <= cfg_data_i[DIR_W-1:0];
        REG_COEF_SOUTH:  coef_s_q    <= cfg_data_i[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Resolve the grid size, the position of the incoming sample and its cell
  always_comb begin
    cols = CmpW'(grid_cols_q);
    if (grid_cols_q == '0) begin
      cols = CmpW'(1);
    end else if (CmpW'(grid_cols_q) > CmpW'(MAX_COLS)) begin
      cols = CmpW'(MAX_COLS);
    end
    rows = CmpW'(grid_rows_q);
    if (grid_rows_q == '0) begin
      rows = CmpW'(1);
    end else if (CmpW'(grid_rows_q) > CmpW'(MAX_ROWS)) begin
      rows = CmpW'(MAX_ROWS);
    end
    bord = (border_q < BORDER_W'(RADIUS)) ? CmpW'(RADIUS) : CmpW'(border_q);

    x0 = frame_start_i ? '0 : CmpW'(col_q);
    y0 = frame_start_i ? '0 : CmpW'(row_q);
    x  = (x0 >= cols) ? '0 : x0;
    y  = (y0 >= rows) ? '0 : y0;
    cr = y - CmpW'(RADIUS);

    interior = (y >= CmpW'(RADIUS)) && (cr >= bord) && ((cr + bord) < rows)
            && (x >= bord) && ((x + bord) < cols);
    is_last  = ((cr + bord + CmpW'(1)) == rows) && ((x + bord + CmpW'(1)) == cols);

    x_inc = x + CmpW'(1);
    y_inc = y + CmpW'(1);

    // Column two samples ahead, wrapped to the start of the next row
    x_rd = x + CmpW'(2);
    if (x_rd >= cols) begin
      x_rd = x_rd - cols;
    end
  end

  // Advance the raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (x_inc >= cols) begin
        col_q <= '0;
        row_q <= (y_inc >= rows) ? '0 : RowW'(y_inc);
      end else begin
        col_q <= ColW'(x_inc);
        row_q <= RowW'(y);
      end
    end
  end

  // Sweep the line store to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + ColW'(1);
      if (clr_addr_q == ColW'(MAX_COLS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Line store: write the sample's lane at column x, read the column two ahead
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      line_mem[clr_addr_q] <= '0;
    end else if (accept) begin
      line_mem[x[ColW-1:0]][y[LANE_W-1:0]] <= sample_i;
    end
    if (accept) begin
      rd_q <= line_mem[x_rd[ColW-1:0]];
    end
  end

  // Shift the column window and the west centers on each transfer
  assign lane_ctr = y[LANE_W-1:0] + LANE_W'(2);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w0_q <= w1_q;
      w1_q <= rd_q;
      c1_q <= w0_q[lane_ctr];
      c2_q <= c1_q;
      s1_smp_q      <= sample_i;
      s1_lane_q     <= y[LANE_W-1:0];
      s1_tag_q.row  <= POS_W'(cr);
      s1_tag_q.col  <= POS_W'(x);
      s1_tag_q.last <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept && interior;
    end
  end

  // Gather the nine taps and their coefficients
  always_comb begin
    ln_n1 = s1_lane_q + LANE_W'(1);
    ln_c  = s1_lane_q + LANE_W'(2);
    ln_s1 = s1_lane_q + LANE_W'(3);

    taps         = '0;
    taps[TAP_C]  = w0_q[ln_c];
    taps[TAP_W1] = c1_q;
    taps[TAP_W2] = c2_q;
    taps[TAP_E1] = w1_q[ln_c];
    taps[TAP_E2] = rd_q[ln_c];
    taps[TAP_N1] = w0_q[ln_n1];
    taps[TAP_N2] = w0_q[s1_lane_q];
    taps[TAP_S1] = w0_q[ln_s1];
    taps[TAP_S2] = s1_smp_q;

    coefs         = '0;
    coefs[TAP_C]  = coef_c_q;
    coefs[TAP_W1] = coef_w_q[COEF_W-1:0];
    coefs[TAP_W2] = coef_w_q[DIR_W-1:COEF_W];
    coefs[TAP_E1] = coef_e_q[COEF_W-1:0];
    coefs[TAP_E2] = coef_e_q[DIR_W-1:COEF_W];
    coefs[TAP_N1] = coef_n_q[COEF_W-1:0];
    coefs[TAP_N2] = coef_n_q[DIR_W-1:COEF_W];
    coefs[TAP_S1] = coef_s_q[COEF_W-1:0];
    coefs[TAP_S2] = coef_s_q[DIR_W-1:COEF_W];
  end

  st2d_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_vld_q),
    .taps_i  (taps),
    .coefs_i (coefs),
    .tag_i   (s1_tag_q),
    .valid_o (mac_vld),
    .res_o   (mac_res)
  );

  st2d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mac_vld),
    .data_i  (mac_res),
    .pop_i   (pop),
    .valid_o (fifo_vld),
    .data_o  (fifo_res)
  );

  // Count results accepted but not yet transferred out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if ((accept && interior) && !pop) begin
      cnt_q <= cnt_q + OUT_CNT_W'(1);
    end else if (pop && !(accept && interior)) begin
      cnt_q <= cnt_q - OUT_CNT_W'(1);
    end
  end

  assign out_valid_o = fifo_vld;
  assign value_o     = fifo_res.value;
  assign row_o       = fifo_res.tag.row;
  assign col_o       = fifo_res.tag.col;
  assign last_o      = fifo_res.tag.last;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("results in flight exceed the queue depth");

  a_mac_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> ##4 mac_vld)
    else $error("interior cell did not leave the multiply pipeline");

  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("result offered with no result outstanding");
`endif

endmodule

/* tb/tb_stencil_2d_star_radius2_unit.sv */
// Self-checking testbench for the radius-2 nine-point star stencil unit.
// Depends on st2d_pkg and stencil_2d_star_radius2_unit; an in-bench stencil
// predictor supplies the expected result for every output transfer.
`timescale 1ns / 1ps

module tb_stencil_2d_star_radius2_unit;
  import st2d_pkg::*;

  localparam int MAX_COLS      = 2048;
  localparam int MAX_ROWS      = 2048;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 350;
  localparam int IDLE_PCT      = 17;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                  frame_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic signed [SAMPLE_W-1:0] value_o;
  logic [POS_W-1:0]      row_o;
  logic [POS_W-1:0]      col_o;
  logic                  last_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predictor copy of the registers and of the stream state
  logic [GRID_W-1:0]   cols_reg;
  logic [GRID_W-1:0]   rows_reg;
  logic [BORDER_W-1:0] border_reg;
  logic [COEF_W-1:0]   coef_c_reg;
  logic [DIR_W-1:0]    coef_w_reg;
  logic [DIR_W-1:0]    coef_e_reg;
  logic [DIR_W-1:0]    coef_n_reg;
  logic [DIR_W-1:0]    coef_s_reg;
  logic [SAMPLE_W-1:0] line_mem [4*MAX_COLS];
  int unsigned         row_pos;
  int unsigned         col_pos;

  st2d_res_t pending_results[$];
  int        fail_count   = 0;
  int        idle_pct     = IDLE_PCT;
  int        stall_pct    = IDLE_PCT;
  int        quiet_cycles = 0;

  stencil_2d_star_radius2_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .row_o         (row_o),
    .col_o         (col_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    st2d_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %h", row_o, col_o, value_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value) begin
          $error("value mismatch: expected %h, actual %h", want.value, value_o);
          fail_count++;
        end
        if (row_o !== want.tag.row) begin
          $error("row mismatch: expected %0d, actual %0d", want.tag.row, row_o);
          fail_count++;
        end
        if (col_o !== want.tag.col) begin
          $error("col mismatch: expected %0d, actual %0d", want.tag.col, col_o);
          fail_count++;
        end
        if (last_o !== want.tag.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.tag.last, last_o);
          fail_count++;
        end
      end
    end
  end

  function automatic longint weighted(input logic [COEF_W-1:0] c,
                                      input logic [SAMPLE_W-1:0] v);
    longint cs;
    longint vs;
    cs = $signed(c);
    vs = $signed(v);
    return cs * vs;
  endfunction

  // Line store word of grid row r (slot r mod 4) at column c
  function automatic logic [SAMPLE_W-1:0] stored(input int unsigned r, input int unsigned c);
    return line_mem[(r % 4) * MAX_COLS + (c % MAX_COLS)];
  endfunction

  // Advance the stencil predictor by one accepted sample
  function automatic void step_stencil(input logic [SAMPLE_W-1:0] s, input logic fs);
    int unsigned         cols;
    int unsigned         rows;
    int unsigned         bnd;
    int unsigned         y;
    int unsigned         x;
    int unsigned         cr;
    logic [SAMPLE_W-1:0] col_taps [4];
    longint              acc;
    st2d_res_t           res;
    cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    bnd  = (border_reg < RADIUS) ? RADIUS : border_reg;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= cols) col_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    y = row_pos;
    x = col_pos;
    // rows y-4 .. y-1 at column x
    for (int k = 0; k < 4; k++) col_taps[k] = stored(y + k, x);
    if (y >= RADIUS) begin
      cr = y - RADIUS;
      if (cr >= bnd && cr + bnd < rows && x >= bnd && x + bnd < cols) begin
        acc = weighted(coef_c_reg, col_taps[2])
            + weighted(coef_w_reg[COEF_W-1:0], stored(cr, x - 1))
            + weighted(coef_w_reg[DIR_W-1:COEF_W], stored(cr, x - 2))
            + weighted(coef_e_reg[COEF_W-1:0], stored(cr, x + 1))
            + weighted(coef_e_reg[DIR_W-1:COEF_W], stored(cr, x + 2))
            + weighted(coef_n_reg[COEF_W-1:0], col_taps[1])
            + weighted(coef_n_reg[DIR_W-1:COEF_W], col_taps[0])
            + weighted(coef_s_reg[COEF_W-1:0], col_taps[3])
            + weighted(coef_s_reg[DIR_W-1:COEF_W], s);
        // round half up, then floor shift
        acc = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (acc > longint'(32'sh7FFF_FFFF)) res.value = SAT_MAX;
        else if (acc < longint'(32'sh8000_0000)) res.value = SAT_MIN;
        else res.value = acc[SAMPLE_W-1:0];
        res.tag.row  = cr[POS_W-1:0];
        res.tag.col  = x[POS_W-1:0];
        res.tag.last = (cr + bnd + 1 == rows) && (x + bnd + 1 == cols);
        pending_results.push_back(res);
      end
    end
    line_mem[(y % 4) * MAX_COLS + x] = s;
    col_pos = x + 1;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return {{11{v[20]}}, v[20:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      2:       return {{8{v[15]}}, v[15:0]};
      default: return v[COEF_W-1:0];
    endcase
  endfunction

  // Send one sample transfer; leave valid high on return at a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    step_stencil(s, fs);
    @(negedge clk_i);
  endtask

  // Write one register; leave cfg valid high on return at a falling edge
  task automatic write_reg(input st2d_cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_GRID_COLS:   cols_reg   = data[GRID_W-1:0];
      REG_GRID_ROWS:   rows_reg   = data[GRID_W-1:0];
      REG_BORDER:      border_reg = data[BORDER_W-1:0];
      REG_COEF_CENTER: coef_c_reg = data[COEF_W-1:0];
      REG_COEF_WEST:   coef_w_reg = data[DIR_W-1:0];
      REG_COEF_EAST:   coef_e_reg = data[DIR_W-1:0];
      REG_COEF_NORTH:  coef_n_reg = data[DIR_W-1:0];
      REG_COEF_SOUTH:  coef_s_reg = data[DIR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Hold the input until every predicted result has been taken
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Drain, then let samples that cause no result leave the pipeline
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Go idle and load geometry plus fresh random coefficients
  task automatic configure(input int unsigned cols, input int unsigned rows,
                           input int unsigned bnd);
    settle();
    write_reg(REG_GRID_COLS, CFG_DATA_W'(cols));
    write_reg(REG_GRID_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_BORDER, CFG_DATA_W'(bnd));
    write_reg(REG_COEF_CENTER, CFG_DATA_W'(rand_coef()));
    write_reg(REG_COEF_WEST, {rand_coef(), rand_coef()});
    write_reg(REG_COEF_EAST, {rand_coef(), rand_coef()});
    write_reg(REG_COEF_NORTH, {rand_coef(), rand_coef()});
    write_reg(REG_COEF_SOUTH, {rand_coef(), rand_coef()});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic stream_frame(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) send_sample(rand_sample(), k == 0);
  endtask

  // Smallest grid with the reset coefficients, extreme samples so the single
  // interior cell saturates
  task automatic test_directed_frame();
    logic [SAMPLE_W-1:0] s;
    int                  r;
    int                  c;
    write_reg(REG_GRID_COLS, CFG_DATA_W'(5));
    write_reg(REG_GRID_ROWS, CFG_DATA_W'(5));
    write_reg(REG_BORDER, CFG_DATA_W'(2));
    cfg_valid_i <= 1'b0;
    for (int idx = 0; idx < 25; idx++) begin
      r = idx / 5;
      c = idx % 5;
      if (r == 2 && c == 2) s = 32'h8000_0000;
      else if ((r == 2 || c == 2) && (r == 1 || r == 3 || c == 1 || c == 3))
        s = 32'h7FFF_FFFF;
      else if (r == 2 || c == 2) s = 32'h8000_0000;
      else s = (idx % 2) ? 32'hFFFF_FFFF : 32'h0000_0001;
      send_sample(s, idx == 0);
    end
  endtask

  // Sizes and borders at and beyond their limits
  task automatic test_size_cases();
    configure(0, 5, 2);        // zero columns act as one
    stream_frame(10);
    configure(5, 0, 2);        // zero rows act as one
    stream_frame(10);
    configure(6, 6, 1);        // border below radius
    stream_frame(36);
    configure(7, 7, 3);        // one interior cell
    stream_frame(49);
    configure(9, 9, 1023);     // empty interior
    stream_frame(81);
    configure(4095, 5, 0);     // widest setting, columns clamp to the maximum
    stream_frame(40);
    configure(5, 4095, 2);     // tallest grid, partial frame only
    stream_frame(60);
  endtask

  // Frame wrap without frame_start, aborted frames and shrinking sizes
  task automatic test_wrap_and_resize();
    configure(6, 6, 2);
    stream_frame(108);
    stream_frame(20);
    stream_frame(36);
    configure(12, 8, 2);
    stream_frame(67);
    configure(6, 5, 2);
    for (int k = 0; k < 40; k++) send_sample(rand_sample(), 1'b0);
  endtask

  // Heavy result stall so the result buffer fills and holds off input
  task automatic test_backpressure();
    configure(16, 10, 2);
    idle_pct  = 0;
    stall_pct = 90;
    stream_frame(160);
    settle();
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  // Back-to-back frames at full rate on both sides
  task automatic test_unbroken_stretch();
    configure(16, 10, 2);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (2) stream_frame(160);
    settle();
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  // Random frames: mostly whole frames, some cut short or broken by a
  // stray frame_start, some paused until all results are out
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned cols;
    int unsigned rows;
    int unsigned bnd;
    int unsigned len;
    int unsigned pause_at;
    logic        fs;
    sent = 0;
    cols = 5;
    rows = 5;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0 || $urandom_range(3) != 0) begin
        cols = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(5, 16);
        rows = $urandom_range(5, 12);
        case ($urandom_range(9))
          0:       bnd = $urandom_range(0, 1);
          1:       bnd = $urandom_range(4, 1023);
          default: bnd = $urandom_range(2, 3);
        endcase
        configure(cols, rows, bnd);
      end
      len = cols * rows;
      if ($urandom_range(9) == 0) len = $urandom_range(1, len - 1);
      pause_at = ($urandom_range(4) == 0) ? $urandom_range(0, len - 1) : len;
      for (int unsigned k = 0; k < len; k++) begin
        fs = (k == 0) || ($urandom_range(99) == 0);
        if (k == pause_at) wait_results();
        send_sample(rand_sample(), fs);
        sent++;
      end
    end
  endtask

  initial begin
    cols_reg   = GRID_COLS_RST;
    rows_reg   = GRID_ROWS_RST;
    border_reg = BORDER_RST;
    coef_c_reg = COEF_C_RST;
    coef_w_reg = COEF_DIR_RST;
    coef_e_reg = COEF_DIR_RST;
    coef_n_reg = COEF_DIR_RST;
    coef_s_reg = COEF_DIR_RST;
    foreach (line_mem[i]) line_mem[i] = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_frame();
    test_size_cases();
    test_wrap_and_resize();
    test_backpressure();
    test_unbroken_stretch();
    test_random_frames();
    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/st2d_pkg.sv
sv/st2d_mac.sv
sv/st2d_fifo.sv
sv/stencil_2d_star_radius2_unit.sv
tb/tb_stencil_2d_star_radius2_unit.sv
